/* rtl/assert_macros.svh */
// Assertion macros shared by the shunt monitor poll sequencer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, held off while reset is high.
`define SMPS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Antecedent in this cycle, consequent in the next one.
`define SMPS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/smps_pkg.sv */
// Shared types and constants of the shunt monitor poll sequencer.
package smps_pkg;

   // sequencer state codes
   localparam logic [2:0] ST_INIT_CFG   = 3'd0;
   localparam logic [2:0] ST_WAIT_CFG   = 3'd1;
   localparam logic [2:0] ST_INIT_CAL   = 3'd2;
   localparam logic [2:0] ST_WAIT_CAL   = 3'd3;
   localparam logic [2:0] ST_IDLE       = 3'd4;
   localparam logic [2:0] ST_WAIT_BUS   = 3'd5;
   localparam logic [2:0] ST_WAIT_SHUNT = 3'd6;

   // device registers and words
   localparam logic [2:0]  REG_CONFIG  = 3'd0;
   localparam logic [2:0]  REG_SHUNT   = 3'd1;
   localparam logic [2:0]  REG_BUS     = 3'd2;
   localparam logic [2:0]  REG_CALIB   = 3'd5;
   localparam logic [15:0] CONFIG_WORD = 16'h399F;
   localparam logic [15:0] CALIB_WORD  = 16'd4096;

   localparam logic [31:0] TIMEOUT_MS = 32'd20;

   // CSR indexes
   localparam logic [2:0] CSR_PERIOD     = 3'd0;
   localparam logic [2:0] CSR_SHUNT      = 3'd1;
   localparam logic [2:0] CSR_CUR_WARN   = 3'd2;
   localparam logic [2:0] CSR_CUR_DANGER = 3'd3;
   localparam logic [2:0] CSR_UND_DANGER = 3'd4;
   localparam logic [2:0] CSR_UND_WARN   = 3'd5;
   localparam logic [2:0] CSR_OVR_WARN   = 3'd6;
   localparam logic [2:0] CSR_OVR_DANGER = 3'd7;

   // CSR reset values
   localparam logic [15:0] RST_PERIOD     = 16'd100;
   localparam logic [9:0]  RST_SHUNT      = 10'd100;
   localparam logic [18:0] RST_CUR_WARN   = 19'd1500;
   localparam logic [18:0] RST_CUR_DANGER = 19'd2000;
   localparam logic [15:0] RST_UND_DANGER = 16'd5000;
   localparam logic [15:0] RST_UND_WARN   = 16'd8000;
   localparam logic [15:0] RST_OVR_WARN   = 16'd12000;
   localparam logic [15:0] RST_OVR_DANGER = 16'd12500;

   // classification codes
   localparam logic [2:0] VCLS_SAFE       = 3'd0;
   localparam logic [2:0] VCLS_UND_DANGER = 3'd1;
   localparam logic [2:0] VCLS_UND_WARN   = 3'd2;
   localparam logic [2:0] VCLS_OVR_WARN   = 3'd3;
   localparam logic [2:0] VCLS_OVR_DANGER = 3'd4;
   localparam logic [1:0] CCLS_SAFE       = 2'd0;
   localparam logic [1:0] CCLS_WARN       = 2'd1;
   localparam logic [1:0] CCLS_DANGER     = 2'd2;

   // shunt microvolt magnitude is at most 327680: 19 bits
   localparam int MAG_W     = 19;
   localparam int DIV_STEPS = MAG_W;
   localparam int CNT_W     = $clog2(DIV_STEPS + 1);
   // ceil(2^30 / 1000): exact floor divide by 1000 for 19-bit values
   localparam int          RECIP_SHIFT = 30;
   localparam int          RECIP_W     = 21;
   localparam logic [20:0] RECIP_1000  = 21'd1073742;
   localparam int          PROD_W      = MAG_W + RECIP_W;

   typedef struct packed {
      logic capture;
      logic exec;
      logic div_step;
      logic commit;
      logic load_out;
   } smps_cmd_type;

   typedef struct packed {
      logic need_div;
      logic div_busy;
   } smps_sts_type;

endpackage

/* rtl/shunt_monitor_poll_sequencer.sv */
// Top level of the shunt monitor poll sequencer: controller plus datapath.
//
//   channel | handshake          | payload
//   --------+--------------------+-----------------------------------------------
//   req     | req_valid/ready    | now_ms, xfer_done/error, read_data, start_ok, init
//   rsp     | rsp_valid/ready    | cmd_*, meas_valid, voltage/current, classes, fault
//   csr     | csr_we (no wait)   | csr_index, csr_wdata
//
// A beat that completes a shunt read passes through capture, one sequencer
// step, the 19 steps of the serial current divider and a drain step, commit, load.
// Every other beat passes through capture, step and load.
// The next beat is taken while a result still waits in the output register.
// Reset is synchronous and puts the sequencer in its idle polling state.
module shunt_monitor_poll_sequencer (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [31:0]        req_now_ms,
   input  logic               req_xfer_done,
   input  logic               req_xfer_error,
   input  logic [15:0]        req_read_data,
   input  logic               req_start_ok,
   input  logic               req_init_req,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_cmd_valid,
   output logic               rsp_cmd_read,
   output logic [2:0]         rsp_cmd_reg,
   output logic [15:0]        rsp_cmd_data,
   output logic               rsp_meas_valid,
   output logic signed [16:0] rsp_volt_mv,
   output logic signed [19:0] rsp_curr_ma,
   output logic [2:0]         rsp_voltage_class,
   output logic [1:0]         rsp_current_class,
   output logic               rsp_fault_now,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [18:0]        csr_wdata
);
   import smps_pkg::*;

   smps_cmd_type cmd;
   smps_sts_type sts;

   smps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   smps_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_now_ms        (req_now_ms),
      .req_xfer_done     (req_xfer_done),
      .req_xfer_error    (req_xfer_error),
      .req_read_data     (req_read_data),
      .req_start_ok      (req_start_ok),
      .req_init_req      (req_init_req),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_cmd_valid     (rsp_cmd_valid),
      .rsp_cmd_read      (rsp_cmd_read),
      .rsp_cmd_reg       (rsp_cmd_reg),
      .rsp_cmd_data      (rsp_cmd_data),
      .rsp_meas_valid    (rsp_meas_valid),
      .rsp_volt_mv       (rsp_volt_mv),
      .rsp_curr_ma       (rsp_curr_ma),
      .rsp_voltage_class (rsp_voltage_class),
      .rsp_current_class (rsp_current_class),
      .rsp_fault_now     (rsp_fault_now)
   );

endmodule

/* rtl/smps_ctrl.sv */
// Controller: input/output handshakes and the phase sequence of one beat.
module smps_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output smps_pkg::smps_cmd_type  cmd,
   input  smps_pkg::smps_sts_type  sts
);
   import smps_pkg::*;

   localparam logic [2:0] C_IDLE   = 3'd0;
   localparam logic [2:0] C_EXEC   = 3'd1;
   localparam logic [2:0] C_DIV    = 3'd2;
   localparam logic [2:0] C_COMMIT = 3'd3;
   localparam logic [2:0] C_FINISH = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         C_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = C_EXEC;
            end
         end
         C_EXEC: begin
            cmd.exec = 1'b1;
            state_in = sts.need_div ? C_DIV : C_FINISH;
         end
         C_DIV: begin
            if (sts.div_busy) begin
               cmd.div_step = 1'b1;
            end else begin
               state_in = C_COMMIT;
            end
         end
         C_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = C_FINISH;
         end
         C_FINISH: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = C_IDLE;
            end
         end
         default: state_in = C_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= C_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == C_IDLE);
   assign rsp_valid = rsp_valid_ff;

`include "assert_macros.svh"

   `SMPS_ASSERT(a_load_free, cmd.load_out |-> (!rsp_valid_ff || rsp_ready), "result loaded over a waiting beat")
   `SMPS_ASSERT_NEXT(a_accept_exec, req_valid && req_ready, state_ff == C_EXEC, "accepted beat not executed")
   `SMPS_ASSERT(a_step_busy, cmd.div_step |-> sts.div_busy, "divider stepped while idle")

endmodule

/* rtl/smps_dp.sv */
// Datapath: CSRs, sequencer state, serial divider and result registers.
module smps_dp (
   input  logic                    clock,
   input  logic                    reset,
   input  smps_pkg::smps_cmd_type  cmd,
   output smps_pkg::smps_sts_type  sts,
   input  logic [31:0]             req_now_ms,
   input  logic                    req_xfer_done,
   input  logic                    req_xfer_error,
   input  logic [15:0]             req_read_data,
   input  logic                    req_start_ok,
   input  logic                    req_init_req,
   input  logic                    csr_we,
   input  logic [2:0]              csr_index,
   input  logic [18:0]             csr_wdata,
   output logic                    rsp_cmd_valid,
   output logic                    rsp_cmd_read,
   output logic [2:0]              rsp_cmd_reg,
   output logic [15:0]             rsp_cmd_data,
   output logic                    rsp_meas_valid,
   output logic signed [16:0]      rsp_volt_mv,
   output logic signed [19:0]      rsp_curr_ma,
   output logic [2:0]              rsp_voltage_class,
   output logic [1:0]              rsp_current_class,
   output logic                    rsp_fault_now
);
   import smps_pkg::*;

   // CSRs
   logic [15:0] period_ff;
   logic [9:0]  shunt_ff;
   logic [18:0] cur_warn_ff, cur_danger_ff;
   logic [15:0] und_danger_ff, und_warn_ff, ovr_warn_ff, ovr_danger_ff;

   // captured beat
   logic [31:0] now_ff;
   logic        xdone_ff, xerr_ff, ok_ff, init_ff;
   logic [15:0] rdata_ff;

   // sequencer state
   logic [2:0]         seq_ff, seq_in;
   logic               done_ff, done_in, err_ff, err_in;
   logic [15:0]        raw_ff, raw_in;
   logic [31:0]        per_ff, per_in, wait_ff, wait_in;
   logic signed [16:0] volt_ff, volt_in, volt_res;
   logic signed [19:0] curr_ff, curr_in, curr_res;
   logic               valid_ff, valid_in;

   // per-beat command staging
   logic        ocv_ff, ocv_in, ocrd_ff, ocrd_in, oflt_ff, oflt_in;
   logic [2:0]  ocreg_ff, ocreg_in;
   logic [15:0] ocdat_ff, ocdat_in;

   // divider and voltage path
   logic [MAG_W-1:0]  quo_ff, mag_ff, mag_in;
   logic [9:0]        rem_ff, dvsr_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              neg_ff;
   logic [14:0]       vbus_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [10:0]       shifted, diff;
   logic              ge;
   logic [15:0]       mag16;
   logic [8:0]        qv;
   logic              go_div, flt, done_v, err_v, wait_bad, due;
   logic [2:0]        vcls;
   logic [1:0]        ccls;

   // ---------------- sequencer step ----------------
   always_comb begin
      done_v   = done_ff | xdone_ff;
      err_v    = err_ff | xerr_ff;
      wait_bad = err_v || ((now_ff - wait_ff) > TIMEOUT_MS);
      due      = (now_ff - per_ff) >= {16'd0, period_ff};
      mag16    = rdata_ff[15] ? (16'd0 - rdata_ff) : rdata_ff;
      mag_in   = {mag16, 3'b000} + {2'b00, mag16, 1'b0};

      seq_in   = seq_ff;
      done_in  = done_v;
      err_in   = err_v;
      raw_in   = raw_ff;
      per_in   = per_ff;
      wait_in  = wait_ff;
      volt_in  = volt_ff;
      curr_in  = curr_ff;
      valid_in = valid_ff;
      ocv_in   = 1'b0;
      ocrd_in  = 1'b0;
      ocreg_in = REG_CONFIG;
      ocdat_in = 16'd0;
      flt      = 1'b0;
      go_div   = 1'b0;

      if (init_ff) begin
         valid_in = 1'b0;
         raw_in   = 16'd0;
         volt_in  = '1;
         curr_in  = '1;
         per_in   = now_ff;
         wait_in  = now_ff;
         done_in  = 1'b0;
         err_in   = 1'b0;
         seq_in   = ST_INIT_CFG;
      end else begin
         case (seq_ff)
            ST_INIT_CFG: begin
               done_in = 1'b0;
               err_in  = 1'b0;
               wait_in = now_ff;
               if (ok_ff) begin
                  ocv_in   = 1'b1;
                  ocreg_in = REG_CONFIG;
                  ocdat_in = CONFIG_WORD;
                  seq_in   = ST_WAIT_CFG;
               end
            end
            ST_WAIT_CFG: begin
               if (wait_bad) begin
                  flt = 1'b1;
               end else if (done_v) begin
                  done_in = 1'b0;
                  err_in  = 1'b0;
                  wait_in = now_ff;
                  if (ok_ff) begin
                     ocv_in   = 1'b1;
                     ocreg_in = REG_CALIB;
                     ocdat_in = CALIB_WORD;
                     seq_in   = ST_WAIT_CAL;
                  end
               end
            end
            ST_INIT_CAL: seq_in = ST_IDLE;
            ST_WAIT_CAL: begin
               if (wait_bad) begin
                  flt = 1'b1;
               end else if (done_v) begin
                  done_in = 1'b0;
                  err_in  = 1'b0;
                  per_in  = now_ff;
                  seq_in  = ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (due) begin
                  per_in  = now_ff;
                  wait_in = now_ff;
                  done_in = 1'b0;
                  err_in  = 1'b0;
                  if (ok_ff) begin
                     ocv_in   = 1'b1;
                     ocrd_in  = 1'b1;
                     ocreg_in = REG_BUS;
                     seq_in   = ST_WAIT_BUS;
                  end else begin
                     flt = 1'b1;
                  end
               end
            end
            ST_WAIT_BUS: begin
               if (wait_bad) begin
                  flt = 1'b1;
               end else if (done_v) begin
                  done_in = 1'b0;
                  raw_in  = rdata_ff;
                  wait_in = now_ff;
                  if (ok_ff) begin
                     ocv_in   = 1'b1;
                     ocrd_in  = 1'b1;
                     ocreg_in = REG_SHUNT;
                     seq_in   = ST_WAIT_SHUNT;
                  end else begin
                     flt = 1'b1;
                  end
               end
            end
            ST_WAIT_SHUNT: begin
               if (wait_bad) begin
                  flt = 1'b1;
               end else if (done_v) begin
                  // results land at commit, after the divide
                  go_div  = 1'b1;
                  done_in = 1'b0;
                  err_in  = 1'b0;
                  seq_in  = ST_IDLE;
               end
            end
            default: flt = 1'b1;
         endcase
         if (flt) begin
            valid_in = 1'b0;
            volt_in  = '1;
            curr_in  = '1;
            seq_in   = ST_INIT_CFG;
            done_in  = 1'b0;
            err_in   = 1'b0;
         end
      end
      oflt_in = flt;
   end

   assign sts.need_div = go_div;
   assign sts.div_busy = (cnt_ff != '0);

   // ---------------- restoring divider ----------------
   assign shifted = {rem_ff, quo_ff[MAG_W-1]};
   assign diff    = shifted - {1'b0, dvsr_ff};
   assign ge      = (shifted >= {1'b0, dvsr_ff});

   // truncation toward zero: divide magnitudes, then apply the sign
   assign qv       = prod_ff[RECIP_SHIFT+8:RECIP_SHIFT];
   assign volt_res = $signed({2'b00, vbus_ff})
                   + (neg_ff ? -$signed({8'd0, qv}) : $signed({8'd0, qv}));
   assign curr_res = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});

   always_ff @(posedge clock) begin
      if (cmd.exec && go_div) begin
         quo_ff  <= mag_in;
         mag_ff  <= mag_in;
         rem_ff  <= 10'd0;
         dvsr_ff <= (shunt_ff == 10'd0) ? 10'd1 : shunt_ff;
         neg_ff  <= rdata_ff[15];
         vbus_ff <= {raw_ff[15:3], 2'b00};
      end else if (cmd.div_step) begin
         quo_ff <= {quo_ff[MAG_W-2:0], ge};
         rem_ff <= ge ? diff[9:0] : shifted[9:0];
      end
      prod_ff <= {{RECIP_W{1'b0}}, mag_ff} * {{MAG_W{1'b0}}, RECIP_1000};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.exec && go_div) begin
         cnt_ff <= CNT_W'(DIV_STEPS);
      end else if (cmd.div_step) begin
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   // ---------------- beat capture and staging ----------------
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         now_ff   <= req_now_ms;
         xdone_ff <= req_xfer_done;
         xerr_ff  <= req_xfer_error;
         rdata_ff <= req_read_data;
         ok_ff    <= req_start_ok;
         init_ff  <= req_init_req;
      end
      if (cmd.exec) begin
         ocv_ff   <= ocv_in;
         ocrd_ff  <= ocrd_in;
         ocreg_ff <= ocreg_in;
         ocdat_ff <= ocdat_in;
         oflt_ff  <= oflt_in;
      end
   end

   // ---------------- architectural state ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff   <= ST_IDLE;
         done_ff  <= 1'b0;
         err_ff   <= 1'b0;
         raw_ff   <= 16'd0;
         per_ff   <= 32'd0;
         wait_ff  <= 32'd0;
         volt_ff  <= '1;
         curr_ff  <= '1;
         valid_ff <= 1'b0;
      end else if (cmd.exec) begin
         seq_ff   <= seq_in;
         done_ff  <= done_in;
         err_ff   <= err_in;
         raw_ff   <= raw_in;
         per_ff   <= per_in;
         wait_ff  <= wait_in;
         volt_ff  <= volt_in;
         curr_ff  <= curr_in;
         valid_ff <= valid_in;
      end else if (cmd.commit) begin
         volt_ff  <= volt_res;
         curr_ff  <= curr_res;
         valid_ff <= 1'b1;
      end
   end

   // ---------------- CSRs ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff     <= RST_PERIOD;
         shunt_ff      <= RST_SHUNT;
         cur_warn_ff   <= RST_CUR_WARN;
         cur_danger_ff <= RST_CUR_DANGER;
         und_danger_ff <= RST_UND_DANGER;
         und_warn_ff   <= RST_UND_WARN;
         ovr_warn_ff   <= RST_OVR_WARN;
         ovr_danger_ff <= RST_OVR_DANGER;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PERIOD:     period_ff     <= csr_wdata[15:0];
            CSR_SHUNT:      shunt_ff      <= csr_wdata[9:0];
            CSR_CUR_WARN:   cur_warn_ff   <= csr_wdata;
            CSR_CUR_DANGER: cur_danger_ff <= csr_wdata;
            CSR_UND_DANGER: und_danger_ff <= csr_wdata[15:0];
            CSR_UND_WARN:   und_warn_ff   <= csr_wdata[15:0];
            CSR_OVR_WARN:   ovr_warn_ff   <= csr_wdata[15:0];
            CSR_OVR_DANGER: ovr_danger_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // ---------------- classification and output register ----------------
   always_comb begin
      // positive voltages fit in 16 bits
      if (volt_ff[16] || (volt_ff == 17'sd0)) begin
         vcls = VCLS_SAFE;
      end else if (volt_ff[15:0] <= und_danger_ff) begin
         vcls = VCLS_UND_DANGER;
      end else if (volt_ff[15:0] <= und_warn_ff) begin
         vcls = VCLS_UND_WARN;
      end else if (volt_ff[15:0] >= ovr_danger_ff) begin
         vcls = VCLS_OVR_DANGER;
      end else if (volt_ff[15:0] >= ovr_warn_ff) begin
         vcls = VCLS_OVR_WARN;
      end else begin
         vcls = VCLS_SAFE;
      end
      if (curr_ff[19]) begin
         ccls = CCLS_SAFE;
      end else if (curr_ff[18:0] >= cur_danger_ff) begin
         ccls = CCLS_DANGER;
      end else if (curr_ff[18:0] >= cur_warn_ff) begin
         ccls = CCLS_WARN;
      end else begin
         ccls = CCLS_SAFE;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_cmd_valid     <= ocv_ff;
         rsp_cmd_read      <= ocrd_ff;
         rsp_cmd_reg       <= ocreg_ff;
         rsp_cmd_data      <= ocdat_ff;
         rsp_meas_valid    <= valid_ff;
         rsp_volt_mv       <= volt_ff;
         rsp_curr_ma       <= curr_ff;
         rsp_voltage_class <= vcls;
         rsp_current_class <= ccls;
         rsp_fault_now     <= oflt_ff;
      end
   end

`include "assert_macros.svh"

   `SMPS_ASSERT_NEXT(a_commit_valid, cmd.commit, valid_ff, "commit left results invalid")
   `SMPS_ASSERT(a_rem_bound, (cnt_ff != '0) |-> (rem_ff < dvsr_ff), "remainder out of range")
   `SMPS_ASSERT(a_fault_state, (cmd.exec && flt) |-> (seq_in == ST_INIT_CFG), "fault skipped init")

endmodule
